FILE: design/scpc_pkg.sv
// Package with the constants and stage types of the skin colour pixel classifier.
`default_nettype none

package scpc_pkg;

  // Widths of the pixel fields and of the configuration port.
  localparam int COLOUR_W    = 8;
  localparam int HUE_W       = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_HUE_LOW  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HUE_HIGH = 4'd1;

  // Whole parts of the hue limits after reset, before scaling to fixed point.
  localparam logic [31:0] HUE_LOW_WHOLE  = 32'd25;
  localparam logic [31:0] HUE_HIGH_WHOLE = 32'd230;

  // Chroma bounds are compared in integers scaled by 10000. Every term is
  // non-negative once the negative slopes are moved to the Cr side, and the
  // largest sum stays below 2**25.
  localparam int CHROMA_W = 25;
  localparam logic [CHROMA_W-1:0] K_CR    = 25'd10000;
  localparam logic [CHROMA_W-1:0] K_UP1   = 25'd15862;
  localparam logic [CHROMA_W-1:0] C_UP1   = 25'd200000;
  localparam logic [CHROMA_W-1:0] K_LO2   = 25'd3448;
  localparam logic [CHROMA_W-1:0] C_LO2   = 25'd762069;
  localparam logic [CHROMA_W-1:0] K_LO3   = 25'd45652;
  localparam logic [CHROMA_W-1:0] C_LO3   = 25'd2345652;
  localparam logic [CHROMA_W-1:0] K_UP4   = 25'd11500;
  localparam logic [CHROMA_W-1:0] C_UP4   = 25'd3017500;
  localparam logic [CHROMA_W-1:0] K_UP5   = 25'd22857;
  localparam logic [CHROMA_W-1:0] C_UP5   = 25'd4328500;

  // RGB rule thresholds.
  localparam logic [COLOUR_W-1:0] DAY_RED_MIN     = 8'd95;
  localparam logic [COLOUR_W-1:0] DAY_GREEN_MIN   = 8'd40;
  localparam logic [COLOUR_W-1:0] DAY_BLUE_MIN    = 8'd20;
  localparam logic [COLOUR_W-1:0] SPREAD_MIN      = 8'd15;
  localparam logic [COLOUR_W-1:0] FLASH_RED_MIN   = 8'd220;
  localparam logic [COLOUR_W-1:0] FLASH_GREEN_MIN = 8'd210;
  localparam logic [COLOUR_W-1:0] FLASH_BLUE_MIN  = 8'd170;

  // First stage: elementary RGB comparisons, the hue decision and the
  // chroma products.
  typedef struct packed {
    logic                r_gt_day;
    logic                g_gt_day;
    logic                b_gt_day;
    logic                r_gt_flash;
    logic                g_gt_flash;
    logic                b_gt_flash;
    logic                r_gt_g;
    logic                r_gt_b;
    logic                g_gt_b;
    logic                drg_gt_spread;
    logic                span_gt_spread;
    logic                hue_hit;
    logic [CHROMA_W-1:0] cr_term;
    logic [CHROMA_W-1:0] up1_prod;
    logic [CHROMA_W-1:0] lo2_prod;
    logic [CHROMA_W-1:0] lo3_prod;
    logic [CHROMA_W-1:0] up4_prod;
    logic [CHROMA_W-1:0] up5_prod;
  } s1_t;

  // Second stage: one bit for each rule.
  typedef struct packed {
    logic rgb_hit;
    logic chroma_hit;
    logic hue_hit;
  } s2_t;

endpackage

`default_nettype wire

FILE: design/skin_color_pixel_classifier_top.sv
// Top level of the skin colour pixel classifier: a three-stage pipeline.
// Usage
//   The input channel carries one pixel per item: R, G, B, Cr, Cb and a hue
//   in unsigned fixed point with HUE_FRAC_BITS fraction bits. The result
//   channel carries one item per pixel: is_skin and the bit of each of the
//   three rules (RGB, chroma, hue). Both channels use valid and stall; an
//   item moves on a rising edge with valid high and stall low. The
//   configuration port writes the low and high hue limits; use it only
//   while the pipeline is empty (not enforced). Unknown indexes are ignored.
// Pipeline and throughput
//   A pixel accepted into stage one passes through stage two to the output
//   register, where it is offered as a result. One pixel is accepted in
//   every cycle while the result channel does not stall. The three stages
//   are: constant products and elementary compares, the five chroma sums and
//   the two RGB branches, and the output register with the final AND.
// Reset
//   A synchronous low rst_n empties the pipeline and loads the hue limits
//   with 25.0 and 230.0 scaled by HUE_FRAC_BITS, saturated at 16 bits.
// Stall
//   When the receiver stalls, the result holds and each stage keeps its item;
//   empty stages behind it still fill, so up to three items are held before
//   in_stall rises. No item is lost or repeated.
`default_nettype none

module skin_color_pixel_classifier_top #(
  parameter int HUE_FRAC_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Configuration port.
  input  wire                                   cfg_wr_en,
  input  wire  [scpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [scpc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // Pixel input channel.
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [scpc_pkg::COLOUR_W-1:0]         in_red,
  input  wire  [scpc_pkg::COLOUR_W-1:0]         in_green,
  input  wire  [scpc_pkg::COLOUR_W-1:0]         in_blue,
  input  wire  [scpc_pkg::COLOUR_W-1:0]         in_chroma_red,
  input  wire  [scpc_pkg::COLOUR_W-1:0]         in_chroma_blue,
  input  wire  [scpc_pkg::HUE_W-1:0]            in_hue_value,
  // Result channel.
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  out_is_skin,
  output logic                                  out_rgb_rule_hit,
  output logic                                  out_chroma_rule_hit,
  output logic                                  out_hue_rule_hit
);

  import scpc_pkg::*;

  // Reset values of the hue limits, saturated when the scaling overflows.
  localparam logic [31:0] HueLowWide  = HUE_LOW_WHOLE << HUE_FRAC_BITS;
  localparam logic [31:0] HueHighWide = HUE_HIGH_WHOLE << HUE_FRAC_BITS;
  localparam logic [HUE_W-1:0] HueLowReset =
    (HueLowWide > 32'h0000_FFFF) ? 16'hFFFF : HueLowWide[HUE_W-1:0];
  localparam logic [HUE_W-1:0] HueHighReset =
    (HueHighWide > 32'h0000_FFFF) ? 16'hFFFF : HueHighWide[HUE_W-1:0];

  // Configuration registers.
  logic [HUE_W-1:0] hue_low_r;
  logic [HUE_W-1:0] hue_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= HueLowReset;
      hue_high_r <= HueHighReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HUE_LOW:  hue_low_r  <= cfg_wdata[HUE_W-1:0];
        REG_HUE_HIGH: hue_high_r <= cfg_wdata[HUE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control. A stage takes a new item when it is empty or
  // when the stage after it takes its present one.
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_ready;
  logic s2_ready;
  logic s1_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;

  // Stage one: elementary comparisons and the constant products.
  s1_t              s1_nxt;
  s1_t              s1_r;
  logic [COLOUR_W-1:0] max_rgb;
  logic [COLOUR_W-1:0] min_rgb;
  logic [COLOUR_W-1:0] diff_rg;

  always_comb begin
    max_rgb = (in_red > in_green) ? in_red : in_green;
    min_rgb = (in_red < in_green) ? in_red : in_green;
    diff_rg = (in_red > in_green) ? (in_red - in_green) : (in_green - in_red);
    if (in_blue > max_rgb) begin
      max_rgb = in_blue;
    end
    if (in_blue < min_rgb) begin
      min_rgb = in_blue;
    end
    s1_nxt.r_gt_day       = in_red > DAY_RED_MIN;
    s1_nxt.g_gt_day       = in_green > DAY_GREEN_MIN;
    s1_nxt.b_gt_day       = in_blue > DAY_BLUE_MIN;
    s1_nxt.r_gt_flash     = in_red > FLASH_RED_MIN;
    s1_nxt.g_gt_flash     = in_green > FLASH_GREEN_MIN;
    s1_nxt.b_gt_flash     = in_blue > FLASH_BLUE_MIN;
    s1_nxt.r_gt_g         = in_red > in_green;
    s1_nxt.r_gt_b         = in_red > in_blue;
    s1_nxt.g_gt_b         = in_green > in_blue;
    s1_nxt.drg_gt_spread  = diff_rg > SPREAD_MIN;
    s1_nxt.span_gt_spread = (max_rgb - min_rgb) > SPREAD_MIN;
    s1_nxt.hue_hit        = (in_hue_value < hue_low_r) || (in_hue_value > hue_high_r);
    s1_nxt.cr_term        = CHROMA_W'(in_chroma_red) * K_CR;
    s1_nxt.up1_prod       = CHROMA_W'(in_chroma_blue) * K_UP1;
    s1_nxt.lo2_prod       = CHROMA_W'(in_chroma_blue) * K_LO2;
    s1_nxt.lo3_prod       = CHROMA_W'(in_chroma_blue) * K_LO3;
    s1_nxt.up4_prod       = CHROMA_W'(in_chroma_blue) * K_UP4;
    s1_nxt.up5_prod       = CHROMA_W'(in_chroma_blue) * K_UP5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage two: the five chroma bounds and the two RGB branches. The
  // negative slopes are added to the Cr side so that every term stays
  // unsigned.
  s2_t  s2_nxt;
  s2_t  s2_r;
  logic day_branch;
  logic flash_branch;

  always_comb begin
    day_branch = s1_r.r_gt_day && s1_r.g_gt_day && s1_r.b_gt_day &&
                 s1_r.span_gt_spread && s1_r.drg_gt_spread &&
                 s1_r.r_gt_g && s1_r.r_gt_b;
    flash_branch = s1_r.r_gt_flash && s1_r.g_gt_flash && s1_r.b_gt_flash &&
                   !s1_r.drg_gt_spread && s1_r.r_gt_b && s1_r.g_gt_b;
    s2_nxt.rgb_hit    = day_branch || flash_branch;
    s2_nxt.chroma_hit = (s1_r.cr_term <= s1_r.up1_prod + C_UP1) &&
                        (s1_r.cr_term >= s1_r.lo2_prod + C_LO2) &&
                        (s1_r.cr_term + s1_r.lo3_prod >= C_LO3) &&
                        (s1_r.cr_term + s1_r.up4_prod <= C_UP4) &&
                        (s1_r.cr_term + s1_r.up5_prod <= C_UP5);
    s2_nxt.hue_hit    = s1_r.hue_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage three: the output register.
  logic out_is_skin_r;
  logic out_rgb_r;
  logic out_chroma_r;
  logic out_hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid_r) begin
      out_is_skin_r <= s2_r.rgb_hit && s2_r.chroma_hit && s2_r.hue_hit;
      out_rgb_r     <= s2_r.rgb_hit;
      out_chroma_r  <= s2_r.chroma_hit;
      out_hue_r     <= s2_r.hue_hit;
    end
  end

  assign out_is_skin         = out_is_skin_r;
  assign out_rgb_rule_hit    = out_rgb_r;
  assign out_chroma_rule_hit = out_chroma_r;
  assign out_hue_rule_hit    = out_hue_r;

`ifndef NO_ASSERTIONS
  // The combined bit always agrees with the three rule bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_skin_r == (out_rgb_r && out_chroma_r && out_hue_r)))
    else $error("is_skin does not match the rule bits");

  // Input is held back only while stage one holds an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with stage one empty");

  // An item held in stage two is not dropped.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_ready) |=> s2_valid_r)
    else $error("stage two lost a held item");

  // An item leaving stage one arrives in stage two.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> s2_valid_r)
    else $error("item lost between stage one and stage two");
`endif

endmodule

`default_nettype wire
